/* src/fasta_tok_pkg.sv */
// fasta_tok_pkg: shared types and constants of the fasta record tokenizer
// transaction structs, token kind codes, controller/datapath command and status
// no dependencies
`default_nettype none

package fasta_tok_pkg;

  // token kinds
  localparam logic [1:0] TK_NAME_BYTE  = 2'd0;
  localparam logic [1:0] TK_NAME_DONE  = 2'd1;
  localparam logic [1:0] TK_SEQ_LETTER = 2'd2;
  localparam logic [1:0] TK_RECORD_END = 2'd3;

  // input transaction
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } byte_item_t;

  // output transaction
  typedef struct packed {
    logic [1:0] token_kind;
    logic [7:0] token_byte;
    logic       last_of_run;
    logic       ws_overflow;
  } token_item_t;

  // where the next token comes from
  typedef enum logic [1:0] {
    SRC_FLUSH,
    SRC_A,
    SRC_B
  } src_sel_t;

  typedef struct packed {
    logic     accept;
    logic     load;
    src_sel_t sel;
    logic     last;
  } ctl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic nx_flush;
    logic nx_a;
    logic nx_b;
    logic has_a;
    logic has_b;
    logic flush_last;
  } dp_status_t;

endpackage

`default_nettype wire

/* src/fasta_record_tokenizer_unit.sv */
// fasta_record_tokenizer_unit: top level of the fasta record tokenizer
// depends on fasta_tok_pkg, fasta_tok_ctrl, fasta_tok_datapath
`default_nettype none

// Takes FASTA text one byte per transaction on the byte channel and emits tokens on
// the token channel: name bytes, name complete, uppercased sequence letters and record
// end, with last_of_run marking the final token caused by each byte. Bytes that cause
// no token stream at one per cycle. A byte that causes tokens holds byte_stall high
// after it is taken until its last token is loaded, since the single output register
// is loaded with one token per cycle while the token side does not stall. Most bytes
// cause at most one token; a byte that releases held name whitespace causes up to
// HELD_WS_DEPTH+1. The last token may still wait in the output register while the next
// byte is taken.

module fasta_record_tokenizer_unit #(
  parameter int HELD_WS_DEPTH = 8
) (
  input  wire                        clk,
  input  wire                        rst,
  // byte channel
  input  wire                        byte_valid,
  output logic                       byte_stall,
  input  fasta_tok_pkg::byte_item_t  byte_data,
  // token channel
  output logic                       token_valid,
  input  wire                        token_stall,
  output fasta_tok_pkg::token_item_t token_data
);
  import fasta_tok_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t status;

  // sequencer: takes a byte, then walks held whitespace, token a, token b
  fasta_tok_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .status     (status),
    .cmd        (cmd)
  );

  // line state, whitespace buffer, per-byte token plan, output register
  fasta_tok_datapath #(
    .HELD_WS_DEPTH (HELD_WS_DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .byte_data   (byte_data),
    .cmd         (cmd),
    .status      (status),
    .token_stall (token_stall),
    .token_valid (token_valid),
    .token_data  (token_data)
  );

endmodule

`default_nettype wire

/* src/fasta_tok_datapath.sv */
// fasta_tok_datapath: line state, held name whitespace, result plan and output register
// depends on fasta_tok_pkg
`default_nettype none

module fasta_tok_datapath #(
  parameter int HELD_WS_DEPTH = 8
) (
  input  wire                        clk,
  input  wire                        rst,
  input  fasta_tok_pkg::byte_item_t  byte_data,
  input  fasta_tok_pkg::ctl_cmd_t    cmd,
  output fasta_tok_pkg::dp_status_t  status,
  input  wire                        token_stall,
  output logic                       token_valid,
  output fasta_tok_pkg::token_item_t token_data
);
  import fasta_tok_pkg::*;

  localparam int CNT_W = $clog2(HELD_WS_DEPTH + 1);
  localparam int IDX_W = (HELD_WS_DEPTH > 1) ? $clog2(HELD_WS_DEPTH) : 1;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_GT    = 8'h3E;

  typedef enum logic [1:0] {
    PH_START,
    PH_HEADER,
    PH_SEQ
  } phase_t;

  function automatic logic is_ws(input logic [7:0] b);
    is_ws = (b == CH_SPACE) || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  // line state
  phase_t           phase, phase_next;
  logic             record_open, record_open_next;
  logic             name_started, name_started_next;
  logic             space_seen, space_seen_next;
  logic [CNT_W-1:0] held_count, held_count_next;
  logic             overflow_seen, overflow_seen_next;
  logic [7:0]       held_ws [HELD_WS_DEPTH];
  logic             hold_wr;

  // result plan of the accepted byte
  logic [CNT_W-1:0] plan_flush_n, nx_flush_n;
  logic             plan_a_valid, nx_a_valid;
  logic [1:0]       plan_a_kind, nx_a_kind;
  logic [7:0]       plan_a_byte, nx_a_byte;
  logic             plan_b_valid, nx_b_valid;
  logic             plan_ov;
  logic [IDX_W-1:0] flush_idx;

  logic [7:0] b;
  logic       b_ws, b_lower, b_upper;
  logic [7:0] b_caps;

  assign b       = byte_data.in_byte;
  assign b_ws    = is_ws(b);
  assign b_lower = (b >= 8'h61) && (b <= 8'h7A);
  assign b_upper = (b >= 8'h41) && (b <= 8'h5A);
  assign b_caps  = b_lower ? (b - 8'h20) : b;

  always_comb begin
    phase_next         = phase;
    record_open_next   = record_open;
    name_started_next  = name_started;
    space_seen_next    = space_seen;
    held_count_next    = held_count;
    overflow_seen_next = overflow_seen;
    hold_wr            = 1'b0;
    nx_flush_n         = '0;
    nx_a_valid         = 1'b0;
    nx_a_kind          = TK_NAME_BYTE;
    nx_a_byte          = 8'h00;
    nx_b_valid         = 1'b0;

    if (byte_data.end_of_input) begin
      nx_a_valid         = (phase == PH_HEADER) && name_started;
      nx_a_kind          = TK_NAME_DONE;
      nx_b_valid         = record_open;
      phase_next         = PH_START;
      name_started_next  = 1'b0;
      space_seen_next    = 1'b0;
      held_count_next    = '0;
      record_open_next   = 1'b0;
      overflow_seen_next = 1'b0;
    end else if (b == CH_LF) begin
      nx_a_valid        = (phase == PH_HEADER) && name_started;
      nx_a_kind         = TK_NAME_DONE;
      phase_next        = PH_START;
      name_started_next = 1'b0;
      space_seen_next   = 1'b0;
      held_count_next   = '0;
    end else begin
      case (phase)
        PH_START: begin
          if (!b_ws) begin
            if (b == CH_GT) begin
              // new header closes the open record
              nx_a_valid         = record_open;
              nx_a_kind          = TK_RECORD_END;
              record_open_next   = 1'b0;
              overflow_seen_next = 1'b0;
              name_started_next  = 1'b0;
              space_seen_next    = 1'b0;
              held_count_next    = '0;
              phase_next         = PH_HEADER;
            end else begin
              phase_next = PH_SEQ;
              if (record_open && (b_lower || b_upper)) begin
                nx_a_valid = 1'b1;
                nx_a_kind  = TK_SEQ_LETTER;
                nx_a_byte  = b_caps;
              end
            end
          end
        end
        PH_HEADER: begin
          if (!name_started) begin
            if (!b_ws) begin
              name_started_next = 1'b1;
              record_open_next  = 1'b1;
              nx_a_valid        = 1'b1;
              nx_a_kind         = TK_NAME_BYTE;
              nx_a_byte         = b;
            end
          end else if (b_ws) begin
            if (!space_seen) begin
              if (b == CH_SPACE) begin
                space_seen_next = 1'b1;
              end else if (held_count < CNT_W'(HELD_WS_DEPTH)) begin
                hold_wr         = 1'b1;
                held_count_next = held_count + 1'b1;
              end else begin
                overflow_seen_next = 1'b1;
              end
            end
          end else begin
            // non-whitespace releases the held bytes
            nx_flush_n      = held_count;
            held_count_next = '0;
            if (!space_seen) begin
              nx_a_valid = 1'b1;
              nx_a_kind  = TK_NAME_BYTE;
              nx_a_byte  = b;
            end
          end
        end
        PH_SEQ: begin
          if (record_open && (b_lower || b_upper)) begin
            nx_a_valid = 1'b1;
            nx_a_kind  = TK_SEQ_LETTER;
            nx_a_byte  = b_caps;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_START;
      record_open   <= 1'b0;
      name_started  <= 1'b0;
      space_seen    <= 1'b0;
      held_count    <= '0;
      overflow_seen <= 1'b0;
      plan_flush_n  <= '0;
      plan_a_valid  <= 1'b0;
      plan_b_valid  <= 1'b0;
      flush_idx     <= '0;
    end else begin
      if (cmd.accept) begin
        phase         <= phase_next;
        record_open   <= record_open_next;
        name_started  <= name_started_next;
        space_seen    <= space_seen_next;
        held_count    <= held_count_next;
        overflow_seen <= overflow_seen_next;
        plan_flush_n  <= nx_flush_n;
        plan_a_valid  <= nx_a_valid;
        plan_b_valid  <= nx_b_valid;
        flush_idx     <= '0;
      end else if (cmd.load && cmd.sel == SRC_FLUSH) begin
        flush_idx <= flush_idx + 1'b1;
      end
    end
  end

  // plan payload and the flag as it stood before the byte
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      plan_a_kind <= nx_a_kind;
      plan_a_byte <= nx_a_byte;
      plan_ov     <= overflow_seen;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && hold_wr) begin
      held_ws[held_count[IDX_W-1:0]] <= b;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      token_valid <= 1'b0;
    end else if (cmd.load) begin
      token_valid <= 1'b1;
    end else if (!token_stall) begin
      token_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      token_data.last_of_run <= cmd.last;
      token_data.ws_overflow <= plan_ov;
      case (cmd.sel)
        SRC_FLUSH: begin
          token_data.token_kind <= TK_NAME_BYTE;
          token_data.token_byte <= held_ws[flush_idx];
        end
        SRC_A: begin
          token_data.token_kind <= plan_a_kind;
          token_data.token_byte <= plan_a_byte;
        end
        default: begin
          token_data.token_kind <= TK_RECORD_END;
          token_data.token_byte <= 8'h00;
        end
      endcase
    end
  end

  assign status.out_free   = !token_valid || !token_stall;
  assign status.nx_flush   = (nx_flush_n != '0);
  assign status.nx_a       = nx_a_valid;
  assign status.nx_b       = nx_b_valid;
  assign status.has_a      = plan_a_valid;
  assign status.has_b      = plan_b_valid;
  assign status.flush_last = ((CNT_W'(flush_idx) + 1'b1) == plan_flush_n);

endmodule

`default_nettype wire

/* src/fasta_tok_ctrl.sv */
// fasta_tok_ctrl: sequencer that accepts a byte and then issues its tokens one per cycle while the output is free
// depends on fasta_tok_pkg
`default_nettype none

module fasta_tok_ctrl (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       byte_valid,
  output logic                      byte_stall,
  input  fasta_tok_pkg::dp_status_t status,
  output fasta_tok_pkg::ctl_cmd_t   cmd
);
  import fasta_tok_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FLUSH,
    S_TOK_A,
    S_TOK_B
  } state_t;

  state_t state;

  assign byte_stall = (state != S_IDLE);

  always_comb begin
    cmd.accept = byte_valid && (state == S_IDLE);
    cmd.load   = status.out_free && (state != S_IDLE);
    unique case (state)
      S_FLUSH: begin
        cmd.sel  = SRC_FLUSH;
        cmd.last = status.flush_last && !status.has_a && !status.has_b;
      end
      S_TOK_A: begin
        cmd.sel  = SRC_A;
        cmd.last = !status.has_b;
      end
      S_TOK_B: begin
        cmd.sel  = SRC_B;
        cmd.last = 1'b1;
      end
      default: begin
        cmd.sel  = SRC_B;
        cmd.last = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd.accept) begin
            if (status.nx_flush) state <= S_FLUSH;
            else if (status.nx_a) state <= S_TOK_A;
            else if (status.nx_b) state <= S_TOK_B;
          end
        end
        S_FLUSH: begin
          if (cmd.load && status.flush_last) begin
            if (status.has_a) state <= S_TOK_A;
            else if (status.has_b) state <= S_TOK_B;
            else state <= S_IDLE;
          end
        end
        S_TOK_A: begin
          if (cmd.load) begin
            state <= status.has_b ? S_TOK_B : S_IDLE;
          end
        end
        S_TOK_B: begin
          if (cmd.load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* src/fasta_tok_checker.sv */
// fasta_tok_checker: port-level assertions for fasta_record_tokenizer_unit and its bind
// depends on fasta_tok_pkg
`default_nettype none

module fasta_tok_checker (
  input wire                        clk,
  input wire                        rst,
  input wire                        byte_valid,
  input wire                        byte_stall,
  input wire                        token_valid,
  input wire                        token_stall,
  input fasta_tok_pkg::token_item_t token_data
);
  import fasta_tok_pkg::*;

  // stalled token transaction holds
  a_token_hold: assert property (@(posedge clk) disable iff (rst)
    token_valid && token_stall |=> token_valid && $stable(token_data))
    else $error("token changed while stalled");

  // the byte side stalls only right after taking a byte
  a_stall_after_accept: assert property (@(posedge clk) disable iff (rst)
    $rose(byte_stall) |-> $past(byte_valid && !byte_stall))
    else $error("byte_stall rose without a byte transaction");

  // marker tokens carry a zero byte
  a_marker_zero: assert property (@(posedge clk) disable iff (rst)
    token_valid && (token_data.token_kind == TK_NAME_DONE ||
                    token_data.token_kind == TK_RECORD_END)
    |-> token_data.token_byte == 8'h00)
    else $error("marker token with nonzero byte");

  // when the byte side frees up, the final token of the run is shown
  a_release_on_last: assert property (@(posedge clk) disable iff (rst)
    $fell(byte_stall) && !$past(rst) |-> token_valid && token_data.last_of_run)
    else $error("byte_stall fell without the last token of the run");

  // a run is not broken by a bubble once a non-final token is taken
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    token_valid && !token_stall && !token_data.last_of_run |=> token_valid)
    else $error("gap inside a token run");

endmodule

bind fasta_record_tokenizer_unit fasta_tok_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .byte_valid  (byte_valid),
  .byte_stall  (byte_stall),
  .token_valid (token_valid),
  .token_stall (token_stall),
  .token_data  (token_data)
);

`default_nettype wire

/* test/tb_fasta_record_tokenizer_unit.sv */
// tb_fasta_record_tokenizer_unit: self-checking bench for the fasta record tokenizer
// drives byte transactions from a directed table and random fasta lines, checks tokens
// against an in-bench tokenizer model or hand-typed expectations; depends on fasta_tok_pkg and the unit under test
`timescale 1ns / 100ps

module tb_fasta_record_tokenizer_unit;
  import fasta_tok_pkg::*;

  localparam int HELD_DEPTH    = 8;
  localparam int RANDOM_TARGET = 325;     // least number of random bytes sent after the directed table
  localparam int DRAIN_CYCLES  = 40;
  localparam int CYCLE_LIMIT   = 300000;

  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_GT  = 8'h3E;

  // where the tokenizer model stands within the current line
  typedef enum logic [1:0] {
    AT_LINE_START,
    IN_HEADER,
    IN_SEQUENCE
  } line_state_t;

  // one byte transaction to send; typed rows carry their expected token by hand
  typedef struct packed {
    byte_item_t  item;
    logic        typed;
    logic        typed_one;
    token_item_t typed_tok;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        byte_valid;
  logic        byte_stall;
  byte_item_t  byte_data;
  logic        token_valid;
  logic        token_stall;
  token_item_t token_data;

  // tokenizer model state
  line_state_t line_state;
  logic        in_record;
  logic        name_begun;
  logic        name_closed;
  logic        name_ws_dropped;
  logic [7:0]  held_ws [HELD_DEPTH];
  int          held_n;

  token_item_t step_tokens[$];      // tokens caused by the byte just modeled
  token_item_t expected_tokens[$];  // tokens still owed by the unit, oldest first
  stim_row_t   pending_rows[$];     // byte transactions waiting to be sent

  int send_idle_pct;
  int recv_idle_pct;
  int sent_bytes;
  int mismatches = 0;
  int cycle_count = 0;

  fasta_record_tokenizer_unit #(
    .HELD_WS_DEPTH(HELD_DEPTH)
  ) uut (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_data  (byte_data),
    .token_valid(token_valid),
    .token_stall(token_stall),
    .token_data (token_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // watchdog: a hung handshake or a missing token ends here
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("tb_fasta_record_tokenizer_unit: errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // tokenizer model
  // ---------------------------------------------------------------------------

  // space, tab, lf, vt, ff, cr
  function automatic logic is_blank(input logic [7:0] b);
    return b == CH_SP || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  task automatic emit_token(input logic [1:0] kind, input logic [7:0] b);
    token_item_t t;
    t.token_kind  = kind;
    t.token_byte  = b;
    t.last_of_run = 1'b0;
    t.ws_overflow = name_ws_dropped;
    step_tokens.insert(step_tokens.size(), t);
  endtask

  task automatic restart_line();
    line_state  = AT_LINE_START;
    name_begun  = 1'b0;
    name_closed = 1'b0;
    held_n      = 0;
  endtask

  // models one accepted byte transaction, leaves its tokens in step_tokens
  task automatic tokenize_byte(input byte_item_t it);
    logic [7:0]  b;
    b = it.in_byte;
    step_tokens.delete();
    if (it.end_of_input) begin
      // end of text closes a name in progress, then the record
      if (line_state == IN_HEADER && name_begun) emit_token(TK_NAME_DONE, 8'h00);
      if (in_record) emit_token(TK_RECORD_END, 8'h00);
      restart_line();
      in_record       = 1'b0;
      name_ws_dropped = 1'b0;
    end else if (b == CH_LF) begin
      if (line_state == IN_HEADER && name_begun) emit_token(TK_NAME_DONE, 8'h00);
      restart_line();
    end else if (line_state == AT_LINE_START) begin
      if (!is_blank(b)) begin
        if (b == CH_GT) begin
          // a new header closes the open record first
          if (in_record) emit_token(TK_RECORD_END, 8'h00);
          in_record       = 1'b0;
          name_ws_dropped = 1'b0;
          name_begun      = 1'b0;
          name_closed     = 1'b0;
          held_n          = 0;
          line_state      = IN_HEADER;
        end else begin
          line_state = IN_SEQUENCE;
        end
      end
    end else if (line_state == IN_HEADER) begin
      if (!name_begun) begin
        if (!is_blank(b)) begin
          name_begun = 1'b1;
          in_record  = 1'b1;
          emit_token(TK_NAME_BYTE, b);
        end
      end else if (is_blank(b)) begin
        if (!name_closed) begin
          if (b == CH_SP) begin
            name_closed = 1'b1;
          end else if (held_n < HELD_DEPTH) begin
            held_ws[held_n] = b;
            held_n++;
          end else begin
            name_ws_dropped = 1'b1;
          end
        end
      end else begin
        // visible byte releases held whitespace, even past the closing space
        for (int i = 0; i < held_n; i++) emit_token(TK_NAME_BYTE, held_ws[i]);
        held_n = 0;
        if (!name_closed) emit_token(TK_NAME_BYTE, b);
      end
    end

    // letters of a sequence line, only inside a named record
    if (line_state == IN_SEQUENCE && !it.end_of_input && b != CH_LF && in_record) begin
      if (b >= 8'h61 && b <= 8'h7A) emit_token(TK_SEQ_LETTER, b - 8'h20);
      else if (b >= 8'h41 && b <= 8'h5A) emit_token(TK_SEQ_LETTER, b);
    end

    if (step_tokens.size() > 0) begin
      step_tokens[step_tokens.size() - 1].last_of_run = 1'b1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus rows
  // ---------------------------------------------------------------------------

  // byte known to cause no token
  task automatic row_quiet(input logic [7:0] b, input logic eoi);
    stim_row_t r;
    r = '0;
    r.item.in_byte      = b;
    r.item.end_of_input = eoi;
    r.typed             = 1'b1;
    pending_rows.insert(pending_rows.size(), r);
  endtask

  // byte known to cause exactly one token, overflow flag clear
  task automatic row_one(input logic [7:0] b, input logic [1:0] kind, input logic [7:0] tok);
    stim_row_t r;
    r = '0;
    r.item.in_byte         = b;
    r.typed                = 1'b1;
    r.typed_one            = 1'b1;
    r.typed_tok.token_kind = kind;
    r.typed_tok.token_byte = tok;
    r.typed_tok.last_of_run = 1'b1;
    pending_rows.insert(pending_rows.size(), r);
  endtask

  // byte whose tokens come from the model
  task automatic row_modeled(input logic [7:0] b, input logic eoi);
    stim_row_t r;
    r = '0;
    r.item.in_byte      = b;
    r.item.end_of_input = eoi;
    pending_rows.insert(pending_rows.size(), r);
  endtask

  function automatic logic [7:0] held_blank();
    case ($urandom_range(3))
      0:       return CH_TAB;
      1:       return 8'h0B;
      2:       return 8'h0C;
      default: return 8'h0D;
    endcase
  endfunction

  function automatic logic [7:0] line_blank();
    return ($urandom_range(3) == 0) ? CH_SP : held_blank();
  endfunction

  function automatic logic [7:0] visible_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    while (is_blank(b)) b = 8'($urandom_range(255));
    return b;
  endfunction

  function automatic logic [7:0] letter();
    logic [7:0] b;
    b = 8'h41 + 8'($urandom_range(25));
    return $urandom_range(1) ? b : (b | 8'h20);
  endfunction

  // one random line of fasta text: mostly well formed headers and sequences
  task automatic queue_random_line();
    int pick;
    int n;
    int burst;
    pick = $urandom_range(99);
    if (pick < 3) begin
      // end of text, may land inside a header or record
      row_modeled(8'($urandom_range(255)), 1'b1);
    end else if (pick < 10) begin
      // raw noise
      repeat ($urandom_range(1, 8)) row_modeled(8'($urandom_range(255)), 1'b0);
    end else if (pick < 18) begin
      // blank or whitespace-only line
      repeat ($urandom_range(0, 3)) row_modeled(line_blank(), 1'b0);
      row_modeled(CH_LF, 1'b0);
    end else if (pick < 48) begin
      // header line
      repeat ($urandom_range(0, 1)) row_modeled(line_blank(), 1'b0);
      row_modeled(CH_GT, 1'b0);
      repeat ($urandom_range(0, 2)) row_modeled(line_blank(), 1'b0);
      if ($urandom_range(9) != 0) begin
        n = $urandom_range(1, 8);
        for (int k = 0; k < n; k++) begin
          if (k > 0 && $urandom_range(3) == 0) begin
            // held whitespace, sometimes past the buffer depth
            burst = ($urandom_range(4) == 0) ? $urandom_range(HELD_DEPTH + 1, HELD_DEPTH + 4)
                                             : $urandom_range(1, 3);
            repeat (burst) row_modeled(held_blank(), 1'b0);
          end
          row_modeled(visible_byte(), 1'b0);
        end
        if ($urandom_range(1)) begin
          // closing space, then a tail that may release held whitespace
          if ($urandom_range(1)) repeat ($urandom_range(1, 3)) row_modeled(held_blank(), 1'b0);
          row_modeled(CH_SP, 1'b0);
          repeat ($urandom_range(0, 4))
            row_modeled($urandom_range(1) ? line_blank() : visible_byte(), 1'b0);
        end else begin
          // trailing held whitespace that is never released
          repeat ($urandom_range(0, 2)) row_modeled(held_blank(), 1'b0);
        end
      end
      row_modeled(CH_LF, 1'b0);
    end else begin
      // sequence line, a few stray bytes among the letters
      repeat ($urandom_range(0, 1)) row_modeled(line_blank(), 1'b0);
      repeat ($urandom_range(1, 14))
        row_modeled(($urandom_range(9) == 0) ? 8'($urandom_range(255)) : letter(), 1'b0);
      row_modeled(CH_LF, 1'b0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // byte channel driver
  // ---------------------------------------------------------------------------

  // called at a rising edge; returns at the edge where the transaction is taken
  task automatic send_row(input stim_row_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_data  <= r.item;
    // stall is settled by the falling edge, inputs only move on the rising one
    @(negedge clk);
    while (byte_stall) @(negedge clk);
    tokenize_byte(r.item);
    sent_bytes++;
    if (r.typed) begin
      if (r.typed_one) expected_tokens.insert(expected_tokens.size(), r.typed_tok);
    end else begin
      foreach (step_tokens[i]) expected_tokens.insert(expected_tokens.size(), step_tokens[i]);
    end
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // token channel: random stall and checking
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst) begin
      token_stall <= 1'b0;
    end else begin
      token_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // a token transaction completes at the next rising edge when valid and not stalled
  always @(negedge clk) begin : token_check
    token_item_t want;
    if (!rst && token_valid === 1'b1 && token_stall === 1'b0) begin
      if (expected_tokens.size() == 0) begin
        $display("%0t ns: unexpected token, expected none, actual kind %0d byte %02h",
                 $time, token_data.token_kind, token_data.token_byte);
        mismatches = mismatches + 1;
      end else begin
        want = expected_tokens.pop_front();
        if (token_data.token_kind !== want.token_kind) begin
          $display("%0t ns: token_kind expected %0d actual %0d",
                   $time, want.token_kind, token_data.token_kind);
          mismatches = mismatches + 1;
        end
        if (token_data.token_byte !== want.token_byte) begin
          $display("%0t ns: token_byte expected %02h actual %02h",
                   $time, want.token_byte, token_data.token_byte);
          mismatches = mismatches + 1;
        end
        if (token_data.last_of_run !== want.last_of_run) begin
          $display("%0t ns: last_of_run expected %0d actual %0d",
                   $time, want.last_of_run, token_data.last_of_run);
          mismatches = mismatches + 1;
        end
        if (token_data.ws_overflow !== want.ws_overflow) begin
          $display("%0t ns: ws_overflow expected %0d actual %0d",
                   $time, want.ws_overflow, token_data.ws_overflow);
          mismatches = mismatches + 1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    rst           = 1'b1;
    byte_valid    = 1'b0;
    byte_data     = '0;
    send_idle_pct = 33;
    recv_idle_pct = 51;
    sent_bytes    = 0;

    // model starts from reset
    restart_line();
    in_record       = 1'b0;
    name_ws_dropped = 1'b0;

    // directed table
    row_quiet(8'h41, 1'b0);                      // letter before any header
    row_quiet(8'hFF, 1'b1);                      // end of text with nothing open
    row_quiet(CH_SP, 1'b0);                      // leading blank
    row_quiet(CH_GT, 1'b0);                      // header after leading blank
    row_quiet(CH_TAB, 1'b0);                     // blank before the name
    row_one(8'hFF, TK_NAME_BYTE, 8'hFF);         // top byte value as a name byte
    row_modeled(8'h0B, 1'b0);                    // vt held inside the name
    row_modeled(8'h0C, 1'b0);                    // ff held inside the name
    row_modeled(8'h78, 1'b0);                    // releases both held bytes
    row_modeled(8'h0D, 1'b0);                    // cr held
    row_modeled(CH_SP, 1'b0);                    // space closes the name
    row_modeled(8'h71, 1'b0);                    // after the space: releases only the cr
    row_one(CH_LF, TK_NAME_DONE, 8'h00);         // newline completes the name
    row_one(8'h61, TK_SEQ_LETTER, 8'h41);        // lowercase a is uppercased
    row_one(8'h7A, TK_SEQ_LETTER, 8'h5A);        // lowercase z is uppercased
    row_quiet(CH_GT, 1'b0);                      // '>' inside a sequence line dropped
    row_quiet(8'h00, 1'b0);                      // zero byte dropped
    row_quiet(CH_LF, 1'b0);
    row_one(CH_GT, TK_RECORD_END, 8'h00);        // new header closes the open record
    row_quiet(CH_LF, 1'b0);                      // empty name opens no record
    row_quiet(8'h67, 1'b0);                      // letter with no record is dropped
    row_modeled(CH_LF, 1'b0);
    row_modeled(CH_GT, 1'b0);
    row_one(8'h4E, TK_NAME_BYTE, 8'h4E);
    row_modeled(CH_LF, 1'b1);                    // end of text inside a name

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (pending_rows.size() > 0) send_row(pending_rows.pop_front());

    // random part: receiver-heavy idling, then sender-heavy, then none
    sent_bytes = 0;
    while (sent_bytes < RANDOM_TARGET) begin
      if (sent_bytes >= 2 * RANDOM_TARGET / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (sent_bytes >= RANDOM_TARGET / 3) begin
        send_idle_pct = 51;
        recv_idle_pct = 33;
      end
      queue_random_line();
      while (pending_rows.size() > 0) send_row(pending_rows.pop_front());
    end
    byte_valid <= 1'b0;

    // drain, then watch for stray tokens
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb_fasta_record_tokenizer_unit: clean");
    end else begin
      $display("tb_fasta_record_tokenizer_unit: errors");
    end
    $finish;
  end

endmodule
